### rtl/pendulum_rk4_step_defines.svh
// ----------------------------------------------------------------------------
// pendulum rk4 step assertion macros
// shared property shapes used by the port checker
// ----------------------------------------------------------------------------
`ifndef PENDULUM_RK4_STEP_DEFINES_SVH
`define PENDULUM_RK4_STEP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PRK4_ASSERT_SAME(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("pendulum_rk4_step check failed");

// next-cycle implication, disabled in reset
`define PRK4_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("pendulum_rk4_step check failed");

`endif

### rtl/prk4_pkg.sv
// ----------------------------------------------------------------------------
// prk4_pkg
// types and constants of the fixed-point rk4 pendulum integrator
// ----------------------------------------------------------------------------
package prk4_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic REG_GOL = 1'b0;
    localparam logic REG_DT  = 1'b1;

    localparam logic [31:0] GOL_RESET = 32'd164584489;
    localparam logic [23:0] DT_RESET  = 24'd167772;

    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    localparam int ATAN_LEN = 30;
    localparam logic [30:0] ATAN_Q30 [0:ATAN_LEN-1] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
        31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536,
        31'd32768, 31'd16384, 31'd8192, 31'd4096, 31'd2048,
        31'd1024, 31'd512, 31'd256, 31'd128, 31'd64,
        31'd32, 31'd16, 31'd8, 31'd4, 31'd2
    };

    // rounding shifts of the stage updates
    localparam logic [4:0] SH_SINE   = 5'd30;
    localparam logic [4:0] SH_HALF_T = 5'd21;
    localparam logic [4:0] SH_HALF_O = 5'd25;
    localparam logic [4:0] SH_FULL_T = 5'd20;
    localparam logic [4:0] SH_FULL_O = 5'd24;

    typedef struct packed {
        logic              command;
        logic signed [31:0] start_angle;
        logic signed [31:0] start_rate;
    } req_t;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] angular_rate;
        logic [31:0]        steps_taken;
        logic               overflow;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_REDUCE, ST_INIT, ST_ITER, ST_MULG, ST_KDERIV, ST_MULT, ST_ADDT,
        ST_MULO, ST_ADDO, ST_FMUL, ST_DIVGO, ST_DIVWAIT, ST_FADD, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_START, OP_REDUCE, OP_INIT, OP_ITER, OP_MULG, OP_KDERIV,
        OP_MULT, OP_ADDT, OP_MULO, OP_ADDO, OP_FMUL, OP_DIVGO, OP_FADD, OP_PUSH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] stage;
        logic       fsel;
        logic [4:0] iter;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

endpackage

### rtl/pendulum_rk4_step.sv
// ----------------------------------------------------------------------------
// pendulum_rk4_step
// fixed-point rk4 integrator of a nonlinear pendulum
// ----------------------------------------------------------------------------
// req (valid/ready) carries one word: a load sets angle and rate and clears
// the step count, a step advances the state by one rk4 step.
// rsp (valid/ready) returns one word per request: angle, rate, step count and
// the saturation flag of that request.
// the user must write g/L and dt over the apb port only while the block is
// idle; the block itself does not enforce it. the step time is set by four
// sine evaluations on one iterative cordic of N = min(CORDIC_ITERATIONS, 30)
// iterations, each with its multiply, the rate updates on one shared
// multiplier and two passes of a divide-by-three unit at 8 bits per cycle.
// one request is in work at a time; req_ready is high only while idle.
// the result sits in an output register, so a new request is taken while
// it waits; if rsp is still stalled when the next result is done, the block
// holds it until the output word is taken.
// reset clears the state to zero and loads the default g/L and dt.
// ----------------------------------------------------------------------------
module pendulum_rk4_step
#(
    parameter int CORDIC_ITERATIONS = 24
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  prk4_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output prk4_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import prk4_pkg::*;

    cmd_t cmd;
    stat_t stat;
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    prk4_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_command (req.command),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    prk4_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_sel   (paddr[2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata)
    );

endmodule

### rtl/prk4_div3.sv
// ----------------------------------------------------------------------------
// prk4_div3
// unsigned divide by three, eight quotient bits per cycle
// ----------------------------------------------------------------------------
module prk4_div3
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    output logic [39:0] quotient,
    output logic        done
);
    logic [39:0] work_reg, work_next;
    logic [1:0]  rem_reg, rem_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;

    always_comb
    begin
        logic [1:0] r;
        logic [2:0] r2;
        logic [7:0] qb;
        r = rem_reg;
        qb = '0;
        for (int j = 7; j >= 0; j--)
        begin
            r2 = {r, work_reg[32 + j]};
            qb[j] = (r2 >= 3'd3);
            r = qb[j] ? 2'(r2 - 3'd3) : r2[1:0];
        end
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            cnt_next  = 3'd5;
        end
        else if (cnt_reg != 3'd0)
        begin
            work_next = {work_reg[31:0], qb};
            rem_next  = r;
            cnt_next  = cnt_reg - 3'd1;
            done_next = (cnt_reg == 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign quotient = work_reg;
    assign done     = done_reg;

endmodule

### rtl/prk4_datapath.sv
// ----------------------------------------------------------------------------
// prk4_datapath
// state, config registers, cordic, shared multiplier and rounding adders
// ----------------------------------------------------------------------------
module prk4_datapath
(
    input  logic            clk,
    input  logic            rst_n,
    input  prk4_pkg::cmd_t  cmd,
    output prk4_pkg::stat_t stat,
    input  prk4_pkg::req_t  req,
    output prk4_pkg::rsp_t  rsp,
    input  logic            cfg_we,
    input  logic            cfg_sel,
    input  logic [31:0]     cfg_wdata,
    output logic [31:0]     cfg_rdata
);
    import prk4_pkg::*;

    function automatic logic signed [65:0] round_shr(input logic signed [63:0] p,
                                                     input logic [4:0] sh);
        logic signed [64:0] pe;
        logic [64:0] mag;
        logic [64:0] half;
        logic [64:0] q;
        pe   = {p[63], p};
        mag  = pe[64] ? 65'(-pe) : 65'(pe);
        half = 65'd1 << (sh - 5'd1);
        q    = (mag + half) >> sh;
        return p[63] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic logic [31:0] sat_val(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -66'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic sat_hit(input logic signed [65:0] v);
        return (v > 66'sd2147483647) || (v < -66'sd2147483648);
    endfunction

    logic [31:0]        gol_reg, gol_next;
    logic [23:0]        dt_reg, dt_next;
    logic signed [31:0] angle_reg, angle_next;
    logic signed [31:0] rate_reg, rate_next;
    logic [31:0]        count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic signed [31:0] th_reg, th_next;
    logic signed [31:0] om_reg, om_next;
    logic signed [31:0] ko_reg, ko_next;
    logic signed [34:0] sum_t_reg, sum_t_next;
    logic signed [34:0] sum_o_reg, sum_o_next;
    logic signed [33:0] m_reg, m_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               neg_reg, neg_next;
    rsp_t               rsp_reg, rsp_next;

    logic signed [34:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [68:0] mul_p;
    logic               div_start;
    logic [39:0]        div_in;
    logic [39:0]        div_q;
    logic               div_done;

    prk4_div3 u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .quotient (div_q),
        .done     (div_done)
    );

    assign stat.div_done = div_done;
    assign cfg_rdata = (cfg_sel == REG_DT) ? {8'd0, dt_reg} : gol_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = 35'(om_reg);
        mul_b = $signed({10'd0, dt_reg});
        unique case (cmd.op)
            OP_MULG:
            begin
                mul_a = $signed({3'd0, gol_reg});
                mul_b = y_reg;
            end
            OP_MULO: mul_a = 35'(ko_reg);
            OP_FMUL: mul_a = cmd.fsel ? sum_o_reg : sum_t_reg;
            default: mul_a = 35'(om_reg);
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        logic signed [33:0] v;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] at;
        logic signed [65:0] s;
        logic signed [65:0] r;
        logic [63:0]        mag;
        logic [63:0]        biased;
        logic signed [31:0] base;
        logic               two;

        gol_next   = gol_reg;
        dt_next    = dt_reg;
        angle_next = angle_reg;
        rate_next  = rate_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        th_next    = th_reg;
        om_next    = om_reg;
        ko_next    = ko_reg;
        sum_t_next = sum_t_reg;
        sum_o_next = sum_o_reg;
        m_next     = m_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        rsp_next   = rsp_reg;
        div_start  = 1'b0;
        div_in     = '0;
        v    = '0;
        dx   = y_reg >>> cmd.iter;
        dy   = x_reg >>> cmd.iter;
        at   = $signed({3'd0, ATAN_Q30[cmd.iter]});
        s    = '0;
        r    = '0;
        mag  = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        biased = '0;
        base = cmd.fsel ? rate_reg : angle_reg;
        two  = (cmd.stage == 2'd1) || (cmd.stage == 2'd2);

        if (cfg_we)
        begin
            if (cfg_sel == REG_GOL)
                gol_next = cfg_wdata;
            else
                dt_next = cfg_wdata[23:0];
        end

        unique case (cmd.op)
            OP_LOAD:
            begin
                angle_next = req.start_angle;
                rate_next  = req.start_rate;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            OP_START:
            begin
                th_next    = angle_reg;
                om_next    = rate_reg;
                sum_t_next = '0;
                sum_o_next = '0;
                ovf_next   = 1'b0;
            end
            OP_REDUCE:
            begin
                // bring the angle into [-pi, pi)
                v = 34'(th_reg);
                if (v >= PI_Q28)
                    v = v - TWO_PI_Q28;
                else if (v < -PI_Q28)
                    v = v + TWO_PI_Q28;
                m_next = v;
            end
            OP_INIT:
            begin
                // fold into [-pi/2, pi/2], then Q4.28 to Q2.30
                v = m_reg;
                if (v > HALF_PI_Q28)
                    v = PI_Q28 - v;
                else if (v < -HALF_PI_Q28)
                    v = -PI_Q28 - v;
                z_next = v <<< 2;
                x_next = GAIN_Q30;
                y_next = '0;
            end
            OP_ITER:
            begin
                if (!z_reg[33])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
            end
            OP_MULG, OP_MULT, OP_MULO, OP_FMUL:
            begin
                prod_next = mul_p[63:0];
            end
            OP_KDERIV:
            begin
                r = -round_shr(prod_reg, SH_SINE);
                ko_next  = sat_val(r);
                ovf_next = ovf_reg | sat_hit(r);
                sum_t_next = sum_t_reg + (two ? (35'(om_reg) <<< 1) : 35'(om_reg));
                sum_o_next = sum_o_reg + (two ? (35'($signed(sat_val(r))) <<< 1)
                                              : 35'($signed(sat_val(r))));
            end
            OP_ADDT:
            begin
                s = 66'(angle_reg) +
                    round_shr(prod_reg, (cmd.stage == 2'd2) ? SH_FULL_T : SH_HALF_T);
                th_next  = sat_val(s);
                ovf_next = ovf_reg | sat_hit(s);
            end
            OP_ADDO:
            begin
                s = 66'(rate_reg) +
                    round_shr(prod_reg, (cmd.stage == 2'd2) ? SH_FULL_O : SH_HALF_O);
                om_next  = sat_val(s);
                ovf_next = ovf_reg | sat_hit(s);
            end
            OP_DIVGO:
            begin
                // round(|p| / (6 * 2^k)) = floor(((|p| + 3 * 2^k) >> (k + 1)) / 3)
                neg_next  = prod_reg[63];
                if (cmd.fsel)
                    biased = (mag + (64'd3 << SH_FULL_O)) >> (SH_FULL_O + 5'd1);
                else
                    biased = (mag + (64'd3 << SH_FULL_T)) >> (SH_FULL_T + 5'd1);
                div_in    = biased[39:0];
                div_start = 1'b1;
            end
            OP_FADD:
            begin
                r = $signed({26'd0, div_q});
                s = 66'(base) + (neg_reg ? -r : r);
                ovf_next = ovf_reg | sat_hit(s);
                if (cmd.fsel)
                begin
                    rate_next  = sat_val(s);
                    count_next = count_reg + 32'd1;
                end
                else
                    angle_next = sat_val(s);
            end
            OP_PUSH:
            begin
                rsp_next.angle        = angle_reg;
                rsp_next.angular_rate = rate_reg;
                rsp_next.steps_taken  = count_reg;
                rsp_next.overflow     = ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gol_reg   <= GOL_RESET;
            dt_reg    <= DT_RESET;
            angle_reg <= '0;
            rate_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            gol_reg   <= gol_next;
            dt_reg    <= dt_next;
            angle_reg <= angle_next;
            rate_reg  <= rate_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        th_reg    <= th_next;
        om_reg    <= om_next;
        ko_reg    <= ko_next;
        sum_t_reg <= sum_t_next;
        sum_o_reg <= sum_o_next;
        m_reg     <= m_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

### rtl/prk4_ctrl.sv
// ----------------------------------------------------------------------------
// prk4_ctrl
// sequencer for the four derivative stages and the final update
// ----------------------------------------------------------------------------
module prk4_ctrl
#(
    parameter int CORDIC_ITERATIONS = 24
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic            req_command,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output prk4_pkg::cmd_t  cmd,
    input  prk4_pkg::stat_t stat
);
    import prk4_pkg::*;

    localparam int ITER_N = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
    localparam logic [4:0] ITER_LAST = 5'(ITER_N - 1);

    state_t     state_reg, state_next;
    logic [1:0] stage_reg, stage_next;
    logic       fsel_reg, fsel_next;
    logic [4:0] iter_reg, iter_next;
    logic       valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        fsel_next  = fsel_reg;
        iter_next  = iter_reg;
        valid_next = valid_reg && !rsp_ready;
        cmd.op     = OP_NONE;
        cmd.stage  = stage_reg;
        cmd.fsel   = fsel_reg;
        cmd.iter   = iter_reg;
        req_ready  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    stage_next = '0;
                    if (req_command == CMD_STEP)
                    begin
                        cmd.op     = OP_START;
                        state_next = ST_REDUCE;
                    end
                    else
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_REDUCE:
            begin
                cmd.op     = OP_REDUCE;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.op     = OP_INIT;
                iter_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.op    = OP_ITER;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == ITER_LAST)
                    state_next = ST_MULG;
            end
            ST_MULG:
            begin
                cmd.op     = OP_MULG;
                state_next = ST_KDERIV;
            end
            ST_KDERIV:
            begin
                cmd.op = OP_KDERIV;
                if (stage_reg == 2'd3)
                begin
                    fsel_next  = 1'b0;
                    state_next = ST_FMUL;
                end
                else
                    state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.op     = OP_MULT;
                state_next = ST_ADDT;
            end
            ST_ADDT:
            begin
                cmd.op     = OP_ADDT;
                state_next = ST_MULO;
            end
            ST_MULO:
            begin
                cmd.op     = OP_MULO;
                state_next = ST_ADDO;
            end
            ST_ADDO:
            begin
                cmd.op     = OP_ADDO;
                stage_next = stage_reg + 2'd1;
                state_next = ST_REDUCE;
            end
            ST_FMUL:
            begin
                cmd.op     = OP_FMUL;
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                cmd.op     = OP_DIVGO;
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (stat.div_done)
                    state_next = ST_FADD;
            end
            ST_FADD:
            begin
                cmd.op = OP_FADD;
                if (!fsel_reg)
                begin
                    fsel_next  = 1'b1;
                    state_next = ST_FMUL;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output word is free
                if (!valid_reg || rsp_ready)
                begin
                    cmd.op     = OP_PUSH;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stage_reg <= '0;
            fsel_reg  <= 1'b0;
            iter_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            fsel_reg  <= fsel_next;
            iter_reg  <= iter_next;
            valid_reg <= valid_next;
        end
    end

    assign rsp_valid = valid_reg;

endmodule

### rtl/prk4_checker.sv
// ----------------------------------------------------------------------------
// prk4_checker
// port-level checks of the pendulum rk4 step block
// ----------------------------------------------------------------------------
`include "pendulum_rk4_step_defines.svh"

module prk4_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input prk4_pkg::rsp_t rsp
);
    `PRK4_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `PRK4_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp))
    // one request in work at a time
    `PRK4_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    // a new result word only comes out of a busy block
    `PRK4_ASSERT_SAME(a_result_from_busy, $rose(rsp_valid), !$past(req_ready))

endmodule

bind pendulum_rk4_step prk4_checker u_prk4_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
